// ===== rtl/core/vum_pkg.sv =====
// ----------------------------------------------------------------------------
// vum_pkg
// Shared types and constants of the vu meter led renderer: transaction
// payloads, command codes, register indexes and the divider interface.
// ----------------------------------------------------------------------------
package vum_pkg;

   // default sizing of the frame store
   localparam int DEF_MAX_STRIPS         = 16;
   localparam int DEF_MAX_LEDS_PER_STRIP = 64;
   localparam int NUM_BANDS              = 7;

   // command codes
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_RENDER = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_STRIPS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEDS_PER_STRIP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_AMOUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR_INNER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR_MIDDLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOUR_OUTER  = 3'd5;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam logic [4:0]  RST_NUM_STRIPS     = 5'd1;
   localparam logic [6:0]  RST_LEDS_PER_STRIP = 7'd64;
   localparam logic [7:0]  RST_FADE_AMOUNT    = 8'd20;
   localparam logic [23:0] RST_COLOUR_INNER   = 24'h008000;
   localparam logic [23:0] RST_COLOUR_MIDDLE  = 24'hFFA500;
   localparam logic [23:0] RST_COLOUR_OUTER   = 24'hFF0000;

   // colour zone limits along the bar
   localparam logic [6:0] ZONE_INNER_LAST  = 7'd7;
   localparam logic [6:0] ZONE_MIDDLE_LAST = 7'd11;

   // divider sizing
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = 4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] band_0;
      logic [7:0] band_1;
      logic [7:0] band_2;
      logic [7:0] band_3;
      logic [7:0] band_4;
      logic [7:0] band_5;
      logic [7:0] band_6;
      logic [9:0] pixel_index;
   } vum_req_type;

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
   } vum_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [7:0]       divisor;
   } vum_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } vum_div_rsp_type;

endpackage

// ===== rtl/core/vu_meter_led_renderer_top.sv =====
// ----------------------------------------------------------------------------
// vu_meter_led_renderer_top
// VU meter renderer: frame store, band levels, fade and bar drawing.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_STRIPS*MAX_LEDS_PER_STRIP pixels of
// the frame store to zero, one pixel a cycle, before it takes its first
// transaction. A load stores the band levels; a read goes through the
// registered read port of the frame store and then the response register.
// A render tick first fades all pixels in use, streaming one pixel a cycle
// through the read and write ports of the frame store; then per strip it
// passes the level, latch, reach and centre pixel states (with a band
// position division before the latch when more than seven strips are used)
// and a high and a low state per lit bar offset, since both halves of the
// bar share one write port. The block stalls its input while a transaction is in progress.
module vu_meter_led_renderer_top #(
   parameter int MAX_STRIPS         = vum_pkg::DEF_MAX_STRIPS,
   parameter int MAX_LEDS_PER_STRIP = vum_pkg::DEF_MAX_LEDS_PER_STRIP
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vum_pkg::vum_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vum_pkg::vum_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vum_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vum_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DEPTH  = MAX_STRIPS * MAX_LEDS_PER_STRIP;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b00000000001,
      ST_IDLE   = 11'b00000000010,
      ST_FADE   = 11'b00000000100,
      ST_LEVEL  = 11'b00000001000,
      ST_LDIV   = 11'b00000010000,
      ST_LATCH  = 11'b00000100000,
      ST_RSTART = 11'b00001000000,
      ST_CENTRE = 11'b00010000000,
      ST_BAR_HI = 11'b00100000000,
      ST_BAR_LO = 11'b01000000000,
      ST_READ   = 11'b10000000000
   } vum_state_type;

   vum_state_type state_ff, state_in;

   // configuration registers
   logic [4:0]  num_strips_ff;
   logic [6:0]  leds_ff;
   logic [7:0]  fade_ff;
   logic [23:0] col_inner_ff;
   logic [23:0] col_middle_ff;
   logic [23:0] col_outer_ff;

   logic [vum_pkg::NUM_BANDS-1:0][7:0] bands_ff, bands_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [4:0]        s_ff, s_in;
   logic [10:0]       t_ff, t_in;
   logic [7:0]        level_ff, level_in;
   logic [6:0]        reach_ff, reach_in;
   logic [6:0]        k_ff, k_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vum_pkg::vum_rsp_type rsp_data_ff, rsp_data_in;

   // frame store
   logic [23:0]       frame_mem [DEPTH];
   logic [23:0]       mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [23:0]       mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   // derived values
   logic [4:0]       eff_n;
   logic [6:0]       eff_l;
   logic [11:0]      total_raw;
   logic [CNT_W-1:0] total;
   logic [11:0]      base_raw;
   logic [5:0]       half;
   logic [6:0]       half_up;
   logic [14:0]      reach_num;
   logic [15:0]      reach_sum;
   logic [CNT_W-1:0] addr_centre;
   logic [CNT_W-1:0] addr_hi;
   logic [CNT_W-1:0] addr_lo;
   logic             hi_in_strip;
   logic             lo_in_strip;
   logic [23:0]      zone_col;
   logic [23:0]      faded;
   logic [7:0]       lvl_out;
   logic             req_acc;

   vum_pkg::vum_div_req_type div_req;
   vum_pkg::vum_div_rsp_type div_rsp;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_strips_ff <= vum_pkg::RST_NUM_STRIPS;
         leds_ff       <= vum_pkg::RST_LEDS_PER_STRIP;
         fade_ff       <= vum_pkg::RST_FADE_AMOUNT;
         col_inner_ff  <= vum_pkg::RST_COLOUR_INNER;
         col_middle_ff <= vum_pkg::RST_COLOUR_MIDDLE;
         col_outer_ff  <= vum_pkg::RST_COLOUR_OUTER;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vum_pkg::CSR_NUM_STRIPS:     num_strips_ff <= csr_data[4:0];
            vum_pkg::CSR_LEDS_PER_STRIP: leds_ff       <= csr_data[6:0];
            vum_pkg::CSR_FADE_AMOUNT:    fade_ff       <= csr_data[7:0];
            vum_pkg::CSR_COLOUR_INNER:   col_inner_ff  <= csr_data;
            vum_pkg::CSR_COLOUR_MIDDLE:  col_middle_ff <= csr_data;
            vum_pkg::CSR_COLOUR_OUTER:   col_outer_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      eff_n     = (32'(num_strips_ff) > MAX_STRIPS) ? 5'(MAX_STRIPS) : num_strips_ff;
      eff_l     = (32'(leds_ff) > MAX_LEDS_PER_STRIP) ? 7'(MAX_LEDS_PER_STRIP) : leds_ff;
      total_raw = eff_n * eff_l;
      total     = CNT_W'(total_raw);
      base_raw  = s_ff * eff_l;
      half      = eff_l[6:1];
      half_up   = 7'((8'(eff_l) + 8'd1) >> 1);
      reach_num = level_ff * half_up;
      // divide by 255 as (x + x/256 + 1)/256, exact over the product range
      reach_sum = 16'(reach_num) + 16'(reach_num[14:8]) + 16'd1;
   end

   // bar addressing and colour zones
   always_comb begin
      addr_centre = base_ff + CNT_W'(half);
      addr_hi     = addr_centre + CNT_W'(k_ff);
      addr_lo     = addr_centre - CNT_W'(k_ff);
      hi_in_strip = (8'(half) + 8'(k_ff)) < 8'(eff_l);
      lo_in_strip = k_ff <= 7'(half);
      if (k_ff <= vum_pkg::ZONE_INNER_LAST) begin
         zone_col = col_inner_ff;
      end else if (k_ff <= vum_pkg::ZONE_MIDDLE_LAST) begin
         zone_col = col_middle_ff;
      end else begin
         zone_col = col_outer_ff;
      end
   end

   // saturating fade per channel
   always_comb begin
      faded[23:16] = (mem_q_ff[23:16] > fade_ff) ? mem_q_ff[23:16] - fade_ff : 8'h00;
      faded[15:8]  = (mem_q_ff[15:8] > fade_ff) ? mem_q_ff[15:8] - fade_ff : 8'h00;
      faded[7:0]   = (mem_q_ff[7:0] > fade_ff) ? mem_q_ff[7:0] - fade_ff : 8'h00;
   end

   vum_level u_level (
      .bands  (bands_ff),
      .strip  (s_ff),
      .strips (eff_n),
      .pos    (t_ff),
      .level  (lvl_out)
   );

   vum_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bands_in     = bands_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_addr_in   = rd_addr_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      level_in     = level_ff;
      reach_in     = reach_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      div_req      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cnt_ff);
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_data.cmd)
                  vum_pkg::CMD_LOAD: begin
                     bands_in[0] = req_data.band_0;
                     bands_in[1] = req_data.band_1;
                     bands_in[2] = req_data.band_2;
                     bands_in[3] = req_data.band_3;
                     bands_in[4] = req_data.band_4;
                     bands_in[5] = req_data.band_5;
                     bands_in[6] = req_data.band_6;
                  end
                  vum_pkg::CMD_RENDER: begin
                     cnt_in   = '0;
                     state_in = ST_FADE;
                  end
                  vum_pkg::CMD_READ: begin
                     rd_ok_in  = 32'(req_data.pixel_index) < 32'(total);
                     mem_re    = 1'b1;
                     mem_raddr = ADDR_W'(req_data.pixel_index);
                     state_in  = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_FADE: begin
            // stream reads, write each pixel back in the next cycle
            if (cnt_ff < total) begin
               mem_re     = 1'b1;
               mem_raddr  = ADDR_W'(cnt_ff);
               rd_pend_in = 1'b1;
               rd_addr_in = ADDR_W'(cnt_ff);
               cnt_in     = cnt_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff;
               mem_wdata = faded;
            end
            if (!(cnt_ff < total) && !rd_pend_ff) begin
               s_in     = '0;
               state_in = (eff_n == 5'd0) ? ST_IDLE : ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            base_in = CNT_W'(base_raw);
            if (eff_n > 5'd7) begin
               div_req.start    = 1'b1;
               div_req.dividend = vum_pkg::DIV_W'({s_ff, 10'h000}) +
                                  vum_pkg::DIV_W'({s_ff, 9'h000});
               div_req.divisor  = {3'b000, eff_n - 5'd1};
               state_in         = ST_LDIV;
            end else begin
               state_in = ST_LATCH;
            end
         end
         ST_LDIV: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient[10:0];
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            level_in = lvl_out;
            state_in = ST_RSTART;
         end
         ST_RSTART: begin
            // bar reach from the latched level
            reach_in = reach_sum[14:8];
            k_in     = 7'd1;
            state_in = ST_CENTRE;
         end
         ST_CENTRE: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(addr_centre);
            mem_wdata = col_inner_ff;
            if (reach_ff != 7'd0) begin
               state_in = ST_BAR_HI;
            end else begin
               s_in     = s_ff + 5'd1;
               state_in = (s_ff + 5'd1 == eff_n) ? ST_IDLE : ST_LEVEL;
            end
         end
         ST_BAR_HI: begin
            mem_we    = hi_in_strip;
            mem_waddr = ADDR_W'(addr_hi);
            mem_wdata = zone_col;
            state_in  = ST_BAR_LO;
         end
         ST_BAR_LO: begin
            mem_we    = lo_in_strip;
            mem_waddr = ADDR_W'(addr_lo);
            mem_wdata = zone_col;
            k_in      = k_ff + 7'd1;
            if (k_ff == reach_ff) begin
               s_in     = s_ff + 5'd1;
               state_in = (s_ff + 5'd1 == eff_n) ? ST_IDLE : ST_LEVEL;
            end else begin
               state_in = ST_BAR_HI;
            end
         end
         ST_READ: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pixel_red   = rd_ok_ff ? mem_q_ff[23:16] : 8'h00;
               rsp_data_in.pixel_green = rd_ok_ff ? mem_q_ff[15:8] : 8'h00;
               rsp_data_in.pixel_blue  = rd_ok_ff ? mem_q_ff[7:0] : 8'h00;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // frame store ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= frame_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bands_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         bands_ff     <= bands_in;
      end
      rd_addr_ff  <= rd_addr_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      level_ff    <= level_in;
      reach_ff    <= reach_in;
      k_ff        <= k_in;
      base_ff     <= base_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // divider result only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_LDIV))
      else $error("divider result outside a wait state");

   // an accepted read goes straight to the read state
   assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.cmd == vum_pkg::CMD_READ) |=> (state_ff == ST_READ))
      else $error("read transaction lost");

   // bar offset stays within the reach
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BAR_HI) |-> (k_ff != 7'd0 && k_ff <= reach_ff))
      else $error("bar offset out of range");

   // no frame store write while idle or reading
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE && state_ff != ST_READ))
      else $error("frame store written outside a render");

endmodule

// ===== rtl/core/vum_div.sv =====
// ----------------------------------------------------------------------------
// vum_div
// Restoring divider, one quotient bit per cycle. Used for the band
// interpolation position, whose divisor is the strip count less one.
// ----------------------------------------------------------------------------
module vum_div (
   input  logic                     clock,
   input  logic                     reset,
   input  vum_pkg::vum_div_req_type req,
   output vum_pkg::vum_div_rsp_type rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [vum_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                    rem_ff, rem_in;
   logic [vum_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [7:0]                    dsr_ff, dsr_in;
   logic [8:0]                    trial;
   logic [8:0]                    diff;
   logic                          ge;

   // one restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[vum_pkg::DIV_W-1]};
      ge    = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[vum_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == vum_pkg::DIV_CNT_W'(vum_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/vum_level.sv =====
// ----------------------------------------------------------------------------
// vum_level
// Maps the band levels to the level of one strip: fixed band groups for up
// to seven strips, linear interpolation with an 8-bit fraction beyond.
// ----------------------------------------------------------------------------
module vum_level (
   input  logic [vum_pkg::NUM_BANDS-1:0][7:0] bands,
   input  logic [4:0]                         strip,
   input  logic [4:0]                         strips,
   input  logic [10:0]                        pos,
   output logic [7:0]                         level
);

   logic [2:0]         lo;
   logic [2:0]         hi;
   logic [7:0]         fr;
   logic [7:0]         lvl_a;
   logic [7:0]         lvl_b;
   logic signed [8:0]  delta;
   logic signed [17:0] prod;
   logic signed [17:0] acc;
   logic [7:0]         lerp;
   logic [7:0]         grp;

   function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
      max2 = (a > b) ? a : b;
   endfunction

   // interpolation between neighbouring bands
   always_comb begin
      lo    = pos[10:8];
      fr    = pos[7:0];
      hi    = lo + 3'd1;
      lvl_a = bands[lo];
      lvl_b = bands[hi];
      delta = $signed({1'b0, lvl_b}) - $signed({1'b0, lvl_a});
      prod  = delta * $signed({1'b0, fr});
      acc   = $signed({2'b00, lvl_a, 8'h00}) + prod;
      lerp  = (lo >= 3'd6) ? bands[6] : acc[15:8];
   end

   // fixed band groups
   always_comb begin
      grp = 8'h00;
      case (strips)
         5'd1: begin
            grp = max2(max2(max2(bands[0], bands[1]), max2(bands[2], bands[3])),
                       max2(max2(bands[4], bands[5]), bands[6]));
         end
         5'd2: begin
            if (strip == 5'd0) begin
               grp = max2(max2(bands[0], bands[1]), max2(bands[2], bands[3]));
            end else begin
               grp = max2(max2(bands[4], bands[5]), bands[6]);
            end
         end
         5'd3: begin
            if (strip == 5'd0) begin
               grp = max2(bands[0], bands[1]);
            end else if (strip == 5'd1) begin
               grp = max2(max2(bands[2], bands[3]), bands[4]);
            end else begin
               grp = max2(bands[5], bands[6]);
            end
         end
         5'd4: begin
            case (strip)
               5'd0:    grp = max2(bands[0], bands[1]);
               5'd1:    grp = max2(bands[2], bands[3]);
               5'd2:    grp = max2(bands[4], bands[5]);
               default: grp = bands[6];
            endcase
         end
         5'd5: begin
            case (strip)
               5'd0:    grp = max2(bands[0], bands[1]);
               5'd1:    grp = bands[2];
               5'd2:    grp = bands[3];
               5'd3:    grp = bands[4];
               default: grp = max2(bands[5], bands[6]);
            endcase
         end
         5'd6: begin
            if (strip < 5'd5) begin
               grp = bands[strip[2:0]];
            end else begin
               grp = max2(bands[5], bands[6]);
            end
         end
         5'd7: begin
            grp = (strip < 5'd7) ? bands[strip[2:0]] : 8'h00;
         end
         default: grp = 8'h00;
      endcase
   end

   assign level = (strips > 5'd7) ? lerp : grp;

endmodule
